>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SCS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/scs_pkg.sv
// Types and constants shared by the call scheduler modules.
`default_nettype none
package scs_pkg;

    localparam int LEVEL_W  = 9;
    localparam int PROB_W   = 17;
    localparam int PERIOD_W = 16;
    localparam int FRAC_W   = 16;
    localparam int RATE_W   = 17;
    localparam int TICK_W   = 25;
    localparam int ACC_W    = 32;
    localparam int PROD_W   = ACC_W + RATE_W;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 9'd256;
    localparam logic [RATE_W-1:0]  RATE_RESET = 17'd48000;
    localparam logic [RATE_W-1:0]  FRAC_ONE   = 17'h10000;

    typedef logic [PROD_W-1:0] t_prod;

    typedef enum logic [2:0] {
        PH_LISTEN  = 3'd0,
        PH_INHIBIT = 3'd1,
        PH_PREP    = 3'd2,
        PH_CALL    = 3'd3,
        PH_REST    = 3'd4
    } t_phase;

    // Products taken on the shared multiplier, in issue order. The rate product
    // of the inhibition position is issued only once both of its halves have
    // been summed into the accumulator.
    typedef enum logic [2:0] {
        MUL_INH_LO   = 3'd0,
        MUL_INH_HI   = 3'd1,
        MUL_NEW      = 3'd2,
        MUL_INH_RATE = 3'd3,
        MUL_LAST     = 3'd4,
        MUL_ENTRY    = 3'd5
    } t_mul_op;

    localparam int N_MUL_OPS = 6;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mul_op mul_op;
        logic    wr_en;
        t_mul_op wr_op;
        logic    rescale;
        logic    commit;
    } t_dp_cmd;

endpackage
`default_nettype wire

>>> sv/scs_item_if.sv
// Input channel of the call scheduler: one control tick per beat.
`default_nettype none
interface scs_item_if;
    logic        valid;
    logic        ready;
    logic [8:0]  thresh_level;
    logic [16:0] play_prob;
    logic [15:0] prep_period;
    logic [15:0] call_period;
    logic [15:0] inhibit_low;
    logic [15:0] inhibit_high;
    logic [15:0] rest_period;
    logic [15:0] rand_inhibit;
    logic [15:0] rand_play;

    modport source (
        output valid, thresh_level, play_prob, prep_period, call_period,
               inhibit_low, inhibit_high, rest_period, rand_inhibit, rand_play,
        input  ready
    );
    modport sink (
        input  valid, thresh_level, play_prob, prep_period, call_period,
               inhibit_low, inhibit_high, rest_period, rand_inhibit, rand_play,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/scs_result_if.sv
// Output channel of the call scheduler: one call flag per beat.
`default_nettype none
interface scs_result_if;
    logic valid;
    logic ready;
    logic call_active;

    modport source (output valid, call_active, input ready);
    modport sink (input valid, call_active, output ready);
endinterface
`default_nettype wire

>>> sv/scs_ctrl.sv
// Sequencer that steps the datapath through one control tick.
`default_nettype none
module scs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output scs_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] STEP_LAST = 3'(scs_pkg::N_MUL_OPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_RESC,
        S_COMMIT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       s_slot_free;

    assign s_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                    n_step     = 3'd0;
                end
            end
            S_CALC: begin
                // A product issued in one step lands in its register in the next.
                o_cmd.mul_en = (r_step < STEP_LAST);
                o_cmd.mul_op = scs_pkg::t_mul_op'(r_step);
                o_cmd.wr_en  = (r_step != 3'd0);
                o_cmd.wr_op  = scs_pkg::t_mul_op'(r_step - 3'd1);
                n_step       = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    n_state = S_RESC;
                end
            end
            S_RESC: begin
                o_cmd.rescale = 1'b1;
                n_state       = S_COMMIT;
            end
            S_COMMIT: begin
                if (s_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> sv/scs_datapath.sv
// Phase register, saturating tick counter and shared multiplier of the scheduler.
`default_nettype none
module scs_datapath #(
    parameter int COUNTER_BITS = 26
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire scs_pkg::t_dp_cmd              i_cmd,
    input  wire logic                          i_cfg_we,
    input  wire logic [scs_pkg::RATE_W-1:0]    i_cfg_wdata,
    input  wire logic [scs_pkg::LEVEL_W-1:0]   i_thresh_level,
    input  wire logic [scs_pkg::PROB_W-1:0]    i_play_prob,
    input  wire logic [scs_pkg::PERIOD_W-1:0]  i_prep_period,
    input  wire logic [scs_pkg::PERIOD_W-1:0]  i_call_period,
    input  wire logic [scs_pkg::PERIOD_W-1:0]  i_inhibit_low,
    input  wire logic [scs_pkg::PERIOD_W-1:0]  i_inhibit_high,
    input  wire logic [scs_pkg::PERIOD_W-1:0]  i_rest_period,
    input  wire logic [scs_pkg::FRAC_W-1:0]    i_rand_inhibit,
    input  wire logic [scs_pkg::FRAC_W-1:0]    i_rand_play,
    output logic                               o_call_active
);

    localparam int EW = ((COUNTER_BITS > scs_pkg::TICK_W) ?
                         COUNTER_BITS : scs_pkg::TICK_W) + 3;

    typedef logic signed [EW-1:0]           t_wide;
    typedef logic signed [COUNTER_BITS-1:0] t_cnt;
    typedef logic [scs_pkg::TICK_W-1:0]     t_tick;
    typedef logic [scs_pkg::PERIOD_W-1:0]   t_period;

    localparam t_wide SAT_HI = t_wide'({1'b0, {(COUNTER_BITS-1){1'b1}}});
    localparam t_wide SAT_LO = -SAT_HI - t_wide'(1);
    localparam t_wide W_ONE  = t_wide'(1);

    function automatic t_cnt f_sat(input t_wide v);
        t_cnt res;
        if (v > SAT_HI) begin
            res = SAT_HI[COUNTER_BITS-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[COUNTER_BITS-1:0];
        end else begin
            res = v[COUNTER_BITS-1:0];
        end
        return res;
    endfunction

    function automatic t_wide f_ext_cnt(input t_cnt c);
        return t_wide'(c);
    endfunction

    function automatic t_wide f_ext_tick(input t_tick t);
        return t_wide'(t);
    endfunction

    // Captured tick inputs.
    logic [scs_pkg::LEVEL_W-1:0] r_level;
    logic [scs_pkg::PROB_W-1:0]  r_prob;
    t_period                     r_prep, r_call, r_rest, r_ilo, r_ihi;
    logic [scs_pkg::FRAC_W-1:0]  r_rinh, r_rplay;

    // Model state.
    scs_pkg::t_phase             r_phase, n_phase;
    t_cnt                        r_cnt, n_cnt;
    t_period                     r_lprep, r_lcall, r_lrest;
    logic [scs_pkg::RATE_W-1:0]  r_rate;

    // Multiplier and intermediate results.
    scs_pkg::t_prod              r_prod;
    logic [scs_pkg::ACC_W-1:0]   r_acc;
    t_tick                       r_inh, r_tnew, r_tlast, r_tentry;
    t_cnt                        r_adj;
    logic                        r_call_active;

    t_period                     s_p_new, s_p_last, s_p_entry;
    logic [scs_pkg::ACC_W-1:0]   s_mul_a;
    logic [scs_pkg::RATE_W-1:0]  s_mul_b;
    t_cnt                        s_dec, s_inh_sat, s_entry_sat, s_inh_dec;

    // The period that the running phase follows, its previous value, and the
    // period of the phase that comes next.
    always_comb begin
        s_p_new   = '0;
        s_p_last  = '0;
        s_p_entry = '0;
        case (r_phase)
            scs_pkg::PH_LISTEN: begin
                s_p_entry = r_prep;
            end
            scs_pkg::PH_PREP: begin
                s_p_new   = r_prep;
                s_p_last  = r_lprep;
                s_p_entry = r_call;
            end
            scs_pkg::PH_CALL: begin
                s_p_new   = r_call;
                s_p_last  = r_lcall;
                s_p_entry = r_rest;
            end
            scs_pkg::PH_REST: begin
                s_p_new   = r_rest;
                s_p_last  = r_lrest;
            end
            default: begin
                s_p_new = '0;
            end
        endcase
    end

    // The inhibition position is low*(1-r) + high*r, which never goes negative.
    always_comb begin
        s_mul_a = '0;
        s_mul_b = r_rate;
        unique case (i_cmd.mul_op)
            scs_pkg::MUL_INH_LO: begin
                s_mul_a = scs_pkg::ACC_W'(r_ilo);
                s_mul_b = scs_pkg::FRAC_ONE - scs_pkg::RATE_W'(r_rinh);
            end
            scs_pkg::MUL_INH_HI: begin
                s_mul_a = scs_pkg::ACC_W'(r_ihi);
                s_mul_b = scs_pkg::RATE_W'(r_rinh);
            end
            scs_pkg::MUL_INH_RATE: s_mul_a = r_acc;
            scs_pkg::MUL_NEW:      s_mul_a = scs_pkg::ACC_W'(s_p_new);
            scs_pkg::MUL_LAST:     s_mul_a = scs_pkg::ACC_W'(s_p_last);
            scs_pkg::MUL_ENTRY:    s_mul_a = scs_pkg::ACC_W'(s_p_entry);
            default:               s_mul_a = '0;
        endcase
    end

    assign s_dec       = f_sat(f_ext_cnt(r_adj) - W_ONE);
    assign s_inh_dec   = f_sat(f_ext_cnt(r_cnt) - W_ONE);
    assign s_inh_sat   = f_sat(f_ext_tick(r_inh));
    assign s_entry_sat = f_sat(f_ext_tick(r_tentry));

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        case (r_phase)
            scs_pkg::PH_LISTEN: begin
                if ((r_level != '0) && ({1'b0, r_rplay} < r_prob)) begin
                    n_phase = scs_pkg::PH_PREP;
                    n_cnt   = s_entry_sat;
                end else begin
                    n_phase = scs_pkg::PH_INHIBIT;
                    n_cnt   = s_inh_sat;
                end
            end
            scs_pkg::PH_INHIBIT: begin
                if (r_cnt <= 0) begin
                    n_phase = scs_pkg::PH_LISTEN;
                end
                n_cnt = s_inh_dec;
            end
            scs_pkg::PH_PREP: begin
                n_cnt = s_dec;
                if ((s_dec <= 0) && (r_level == scs_pkg::LEVEL_ONE)) begin
                    n_phase = scs_pkg::PH_CALL;
                    n_cnt   = s_entry_sat;
                end else if (r_level < scs_pkg::LEVEL_ONE) begin
                    n_phase = scs_pkg::PH_INHIBIT;
                    n_cnt   = s_inh_sat;
                end
            end
            scs_pkg::PH_CALL: begin
                n_cnt = s_dec;
                if (s_dec <= 0) begin
                    n_phase = scs_pkg::PH_REST;
                    n_cnt   = s_entry_sat;
                end
            end
            scs_pkg::PH_REST: begin
                n_cnt = s_dec;
                if (s_dec <= 0) begin
                    n_phase = scs_pkg::PH_LISTEN;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Captured inputs and intermediate results need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_level <= i_thresh_level;
            r_prob  <= i_play_prob;
            r_prep  <= i_prep_period;
            r_call  <= i_call_period;
            r_rest  <= i_rest_period;
            r_ilo   <= i_inhibit_low;
            r_ihi   <= i_inhibit_high;
            r_rinh  <= i_rand_inhibit;
            r_rplay <= i_rand_play;
        end
        if (i_cmd.mul_en) begin
            r_prod <= scs_pkg::t_prod'(s_mul_a) * scs_pkg::t_prod'(s_mul_b);
        end
        if (i_cmd.wr_en) begin
            case (i_cmd.wr_op)
                scs_pkg::MUL_INH_LO:   r_acc    <= r_prod[scs_pkg::ACC_W-1:0];
                scs_pkg::MUL_INH_HI:   r_acc    <= r_acc + r_prod[scs_pkg::ACC_W-1:0];
                scs_pkg::MUL_INH_RATE: r_inh    <= r_prod[48:24];
                scs_pkg::MUL_NEW:      r_tnew   <= r_prod[32:8];
                scs_pkg::MUL_LAST:     r_tlast  <= r_prod[32:8];
                scs_pkg::MUL_ENTRY:    r_tentry <= r_prod[32:8];
                default:               r_acc    <= r_acc;
            endcase
        end
        // Keep the ticks already spent when the running period was changed.
        if (i_cmd.rescale) begin
            if (s_p_new != s_p_last) begin
                r_adj <= f_sat(f_ext_tick(r_tnew) - f_ext_tick(r_tlast) + f_ext_cnt(r_cnt));
            end else begin
                r_adj <= r_cnt;
            end
        end
        if (i_cmd.commit) begin
            r_call_active <= (n_phase == scs_pkg::PH_CALL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= scs_pkg::PH_LISTEN;
            r_cnt   <= '0;
            r_lprep <= '0;
            r_lcall <= '0;
            r_lrest <= '0;
            r_rate  <= scs_pkg::RATE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_lprep <= r_prep;
                r_lcall <= r_call;
                r_lrest <= r_rest;
            end
        end
    end

    assign o_call_active = r_call_active;

endmodule
`default_nettype wire

>>> sv/stochastic_call_scheduler.sv
// Each tick is loaded, run through the multiply steps, rescaled and committed;
// ticks are taken one at a time; six products share one 32x17 multiplier.
// The result sits in an output register, so a new tick is taken while it waits.
// Reset (synchronous, active low) sets listening, counter 0, stored periods 0
// and tick_rate 48000; there is no clearing pass.
`default_nettype none
module stochastic_call_scheduler #(
    parameter int COUNTER_BITS = 26
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [scs_pkg::RATE_W-1:0] i_cfg_wdata,
    scs_item_if.sink                        i_req,
    scs_result_if.source                    o_rsp
);

    scs_pkg::t_dp_cmd s_cmd;

    scs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (s_cmd)
    );

    scs_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_thresh_level (i_req.thresh_level),
        .i_play_prob    (i_req.play_prob),
        .i_prep_period  (i_req.prep_period),
        .i_call_period  (i_req.call_period),
        .i_inhibit_low  (i_req.inhibit_low),
        .i_inhibit_high (i_req.inhibit_high),
        .i_rest_period  (i_req.rest_period),
        .i_rand_inhibit (i_req.rand_inhibit),
        .i_rand_play    (i_req.rand_play),
        .o_call_active  (o_rsp.call_active)
    );

endmodule
`default_nettype wire

>>> sv/scs_checker.sv
// Port-level checks of the call scheduler and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"
module scs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_call_active
);

    `SCS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")
    `SCS_ASSERT_RST(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_call_active), "result payload changed while stalled")
    // Ticks are worked one at a time, so an accepted beat closes the input.
    `SCS_ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "input taken again before the tick finished")
    `SCS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid, "result beat shown right after reset")

endmodule

bind stochastic_call_scheduler scs_checker u_scs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_call_active (o_rsp.call_active)
);
`default_nettype wire

>>> verif/tb_stochastic_call_scheduler.sv
// Self-checking testbench for the call scheduler: predicted call flags versus DUT beats.
module tb_stochastic_call_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import scs_pkg::*;

    localparam int     CNT_W          = 26;
    localparam longint CNT_MAX        = (longint'(1) <<< (CNT_W - 1)) - 1;
    localparam longint CNT_MIN        = -CNT_MAX - 1;
    localparam int     RATE_PHASES    = 10;
    localparam int     ITEMS_PER_RATE = 160;
    localparam int     LONG_HOLD      = 600;
    localparam int     CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [LEVEL_W-1:0]  thresh_level;
        logic [PROB_W-1:0]   play_prob;
        logic [PERIOD_W-1:0] prep_period;
        logic [PERIOD_W-1:0] call_period;
        logic [PERIOD_W-1:0] inhibit_low;
        logic [PERIOD_W-1:0] inhibit_high;
        logic [PERIOD_W-1:0] rest_period;
        logic [FRAC_W-1:0]   rand_inhibit;
        logic [FRAC_W-1:0]   rand_play;
    } tick_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [RATE_W-1:0] i_cfg_wdata;

    scs_item_if   tick_if ();
    scs_result_if call_if ();

    stochastic_call_scheduler #(.COUNTER_BITS(CNT_W)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (tick_if),
        .o_rsp       (call_if)
    );

    tick_t tick_queue[$];
    logic  call_flags_due[$];

    // Mirror of the caller state and of the rate register.
    t_phase                phase_q;
    logic signed [CNT_W-1:0] count_q;
    logic [PERIOD_W-1:0]   last_prep;
    logic [PERIOD_W-1:0]   last_call;
    logic [PERIOD_W-1:0]   last_rest;
    logic [RATE_W-1:0]     rate_mirror;

    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned freeze_left;
    int          freezes_asked;
    int          freezes_served;
    bit          rx_frozen;
    bit          idle_on;
    int          fail_count;
    int unsigned cycle_count;
    int unsigned phase_rates[RATE_PHASES] =
        '{256, 1, 96000, 0, 2560, 48000, 131071, 0, 1000, 256};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clamp_count(input longint v);
        if (v > CNT_MAX) return CNT_MAX;
        if (v < CNT_MIN) return CNT_MIN;
        return v;
    endfunction

    function automatic longint period_to_ticks(input logic [PERIOD_W-1:0] p);
        return (longint'(p) * longint'(rate_mirror)) >>> 8;
    endfunction

    function automatic longint inhibit_ticks(input tick_t t);
        longint lo;
        longint hi;
        longint pos;
        lo  = longint'(t.inhibit_low);
        hi  = longint'(t.inhibit_high);
        pos = lo * 65536 + longint'(t.rand_inhibit) * (hi - lo);
        if (pos < 0) pos = 0;
        return (pos * longint'(rate_mirror)) >>> 24;
    endfunction

    // Keeps the ticks already spent when the running phase's period changes.
    function automatic void rescale_count(input logic [PERIOD_W-1:0] now_p,
                                          input logic [PERIOD_W-1:0] old_p);
        longint spent;
        if (now_p != old_p) begin
            spent   = period_to_ticks(old_p) - longint'(count_q);
            count_q = clamp_count(period_to_ticks(now_p) - spent);
        end
    endfunction

    function automatic void count_down();
        count_q = clamp_count(longint'(count_q) - 1);
    endfunction

    function automatic logic advance_caller(input tick_t t);
        longint inh;
        inh = clamp_count(inhibit_ticks(t));
        case (phase_q)
            PH_LISTEN: begin
                if (t.thresh_level != 0 && PROB_W'(t.rand_play) < t.play_prob) begin
                    phase_q = PH_PREP;
                    count_q = clamp_count(period_to_ticks(t.prep_period));
                end else begin
                    phase_q = PH_INHIBIT;
                    count_q = inh;
                end
            end
            PH_INHIBIT: begin
                if (count_q <= 0) phase_q = PH_LISTEN;
                count_down();
            end
            PH_PREP: begin
                rescale_count(t.prep_period, last_prep);
                count_down();
                if (count_q <= 0 && t.thresh_level == LEVEL_ONE) begin
                    phase_q = PH_CALL;
                    count_q = clamp_count(period_to_ticks(t.call_period));
                end else if (t.thresh_level < LEVEL_ONE) begin
                    phase_q = PH_INHIBIT;
                    count_q = inh;
                end
            end
            PH_CALL: begin
                rescale_count(t.call_period, last_call);
                count_down();
                if (count_q <= 0) begin
                    phase_q = PH_REST;
                    count_q = clamp_count(period_to_ticks(t.rest_period));
                end
            end
            PH_REST: begin
                rescale_count(t.rest_period, last_rest);
                count_down();
                if (count_q <= 0) phase_q = PH_LISTEN;
            end
            default: ;
        endcase
        last_prep = t.prep_period;
        last_call = t.call_period;
        last_rest = t.rest_period;
        return phase_q == PH_CALL;
    endfunction

    // Periods are kept to a handful of ticks at the current rate, with a few
    // wide values that the next rescale pulls back.
    function automatic logic [PERIOD_W-1:0] pick_period(input int unsigned cap,
                                                       input bit wide);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (wide && r < 15) return PERIOD_W'($urandom_range(65535, 0));
        if (wide || r < 10) return PERIOD_W'($urandom_range((cap >= 65535) ? 65535 : cap + 1, 0));
        return PERIOD_W'($urandom_range(cap, 0));
    endfunction

    function automatic tick_t random_tick();
        tick_t       t;
        int unsigned cap;
        int unsigned r;
        bit          noisy;
        cap   = (rate_mirror == 0) ? 65535 : 3072 / rate_mirror;
        noisy = ($urandom_range(99, 0) < 15);
        r     = $urandom_range(99, 0);
        if (noisy) begin
            t.thresh_level = LEVEL_W'($urandom_range(511, 0));
            t.play_prob    = (r < 10) ? FRAC_ONE : PROB_W'($urandom_range(65536, 0));
        end else begin
            if (r < 65)      t.thresh_level = LEVEL_ONE;
            else if (r < 77) t.thresh_level = LEVEL_W'($urandom_range(511, 257));
            else             t.thresh_level = LEVEL_W'($urandom_range(255, 0));
            r = $urandom_range(99, 0);
            if (r < 50)      t.play_prob = FRAC_ONE;
            else if (r < 65) t.play_prob = '0;
            else             t.play_prob = PROB_W'($urandom_range(65536, 0));
        end
        t.prep_period  = pick_period(cap, noisy);
        t.call_period  = pick_period(cap, noisy);
        t.rest_period  = pick_period(cap, noisy);
        // Inhibition never rescales, so its bounds stay short.
        t.inhibit_low  = PERIOD_W'($urandom_range(cap, 0));
        t.inhibit_high = PERIOD_W'($urandom_range(cap, 0));
        t.rand_inhibit = FRAC_W'($urandom_range(65535, 0));
        t.rand_play    = FRAC_W'($urandom_range(65535, 0));
        return t;
    endfunction

    // Tick driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            gap_left      <= 0;
        end else if (!tick_if.valid || tick_if.ready) begin
            if (gap_left != 0) begin
                tick_if.valid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (tick_queue.size() != 0) begin
                tick_t t;
                t = tick_queue.pop_front();
                tick_if.thresh_level <= t.thresh_level;
                tick_if.play_prob    <= t.play_prob;
                tick_if.prep_period  <= t.prep_period;
                tick_if.call_period  <= t.call_period;
                tick_if.inhibit_low  <= t.inhibit_low;
                tick_if.inhibit_high <= t.inhibit_high;
                tick_if.rest_period  <= t.rest_period;
                tick_if.rand_inhibit <= t.rand_inhibit;
                tick_if.rand_play    <= t.rand_play;
                tick_if.valid        <= 1'b1;
                if (idle_on && $urandom_range(99, 0) < 12) gap_left <= $urandom_range(17, 1);
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, so the output register fills and ticks back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_frozen      <= 1'b0;
            freeze_left    <= 0;
            freezes_served <= 0;
        end else if (freeze_left != 0) begin
            freeze_left <= freeze_left - 1;
            if (freeze_left == 1) rx_frozen <= 1'b0;
        end else if (freezes_asked != freezes_served) begin
            rx_frozen      <= 1'b1;
            freeze_left    <= LONG_HOLD;
            freezes_served <= freezes_served + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            call_if.ready <= 1'b0;
            stall_left    <= 0;
        end else if (rx_frozen) begin
            call_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            call_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(99, 0) < 10) begin
            call_if.ready <= 1'b0;
            stall_left    <= $urandom_range(16, 0);
        end else begin
            call_if.ready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted tick beat, checks every result beat.
    always @(posedge i_clk) begin : monitor
        tick_t seen;
        logic  want;
        if (!i_rst_n) begin
            phase_q   = PH_LISTEN;
            count_q   = '0;
            last_prep = '0;
            last_call = '0;
            last_rest = '0;
            call_flags_due.delete();
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                seen = '{tick_if.thresh_level, tick_if.play_prob, tick_if.prep_period,
                         tick_if.call_period, tick_if.inhibit_low, tick_if.inhibit_high,
                         tick_if.rest_period, tick_if.rand_inhibit, tick_if.rand_play};
                call_flags_due.push_back(advance_caller(seen));
            end
            if (call_if.valid && call_if.ready) begin
                if (call_flags_due.size() == 0) begin
                    $error("call_active beat with no tick outstanding: got %0b",
                           call_if.call_active);
                    fail_count++;
                end else begin
                    want = call_flags_due.pop_front();
                    if (call_if.call_active !== want) begin
                        $error("call_active mismatch: expected %0b, got %0b",
                               want, call_if.call_active);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || tick_if.valid || call_flags_due.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic set_rate(input logic [RATE_W-1:0] r);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rate_mirror = r;
        @(negedge i_clk);
    endtask

    task automatic queue_tick(input logic [LEVEL_W-1:0] level, input logic [PROB_W-1:0] prob,
                              input logic [PERIOD_W-1:0] prep, input logic [PERIOD_W-1:0] call,
                              input logic [PERIOD_W-1:0] ilo, input logic [PERIOD_W-1:0] ihi,
                              input logic [PERIOD_W-1:0] rest, input logic [FRAC_W-1:0] rinh,
                              input logic [FRAC_W-1:0] rplay);
        tick_queue.push_back('{level, prob, prep, call, ilo, ihi, rest, rinh, rplay});
    endtask

    initial begin
        int unsigned rate;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        tick_if.valid        = 1'b0;
        tick_if.thresh_level = '0;
        tick_if.play_prob    = '0;
        tick_if.prep_period  = '0;
        tick_if.call_period  = '0;
        tick_if.inhibit_low  = '0;
        tick_if.inhibit_high = '0;
        tick_if.rest_period  = '0;
        tick_if.rand_inhibit = '0;
        tick_if.rand_play    = '0;
        call_if.ready        = 1'b0;
        rate_mirror          = RATE_RESET;
        idle_on              = 1'b1;
        freezes_asked        = 0;
        fail_count           = 0;
        cycle_count          = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A zero rate makes every duration zero, so the field extremes are safe
        // and each phase change can be walked one tick at a time.
        set_rate('0);
        queue_tick(9'd0, FRAC_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'h0000);
        queue_tick(9'd0, '0, '0, '0, '0, '0, '0, '0, 16'hFFFF);
        queue_tick(9'd511, FRAC_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                   16'hFFFF, 16'hFFFF);
        // Above one the preparing phase neither calls nor inhibits.
        queue_tick(9'd257, FRAC_ONE, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(LEVEL_ONE, FRAC_ONE, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(LEVEL_ONE, FRAC_ONE, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(LEVEL_ONE, FRAC_ONE, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(9'd1, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(9'd0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(LEVEL_ONE, 17'd1, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(9'd255, FRAC_ONE, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(9'd0, '0, '0, '0, '0, '0, '0, '0, '0);

        // Drive the counter into positive saturation: enter preparing at the top
        // rate, drop the period while the rate is zero, then raise it again.
        set_rate(17'h1FFFF);
        queue_tick(LEVEL_ONE, FRAC_ONE, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        set_rate('0);
        queue_tick(LEVEL_ONE, FRAC_ONE, '0, '0, '0, '0, '0, '0, '0);
        set_rate(17'h1FFFF);
        queue_tick(LEVEL_ONE, FRAC_ONE, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        queue_tick(9'd255, FRAC_ONE, 16'hFFFF, '0, '0, '0, '0, '0, '0);
        queue_tick(9'd0, '0, '0, '0, '0, '0, '0, '0, '0);

        // Reversed inhibition bounds, then a rescale while preparing.
        set_rate(17'd256);
        queue_tick(9'd0, '0, '0, '0, 16'd5, 16'd1, '0, 16'h8000, '0);
        repeat (4) queue_tick(9'd0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_tick(LEVEL_ONE, FRAC_ONE, 16'd2, 16'd1, '0, '0, 16'd1, '0, '0);
        queue_tick(LEVEL_ONE, FRAC_ONE, 16'd4, 16'd1, '0, '0, 16'd1, '0, '0);

        for (int ph = 0; ph < RATE_PHASES; ph++) begin
            rate = (ph == 7) ? $urandom_range(96000, 1) : phase_rates[ph];
            set_rate(RATE_W'(rate));
            if (ph == RATE_PHASES - 1) idle_on = 1'b0;
            for (int i = 0; i < ITEMS_PER_RATE; i++) tick_queue.push_back(random_tick());
            if (ph == 0 || ph == 5) freezes_asked++;
        end
        drain();

        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
